>>> src/periodic_stream_scheduler_top_macros.svh
// assertion macros for the periodic stream scheduler
// used by the files that carry concurrent checks; expects clk and rst_n in scope
`ifndef PERIODIC_STREAM_SCHEDULER_TOP_MACROS_SVH
`define PERIODIC_STREAM_SCHEDULER_TOP_MACROS_SVH

`ifndef ASSERT_OFF
`define PSS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PSS_ASSERT_NEVER(lbl, expr, msg) \
    `PSS_ASSERT(lbl, !(expr), msg)
`else
`define PSS_ASSERT(lbl, prop, msg)
`define PSS_ASSERT_NEVER(lbl, expr, msg)
`endif

`endif

>>> src/pss_pkg.sv
// shared types, constants and helpers of the periodic stream scheduler
// no dependencies; used by every other file of the block but the macros header
package pss_pkg;

    localparam int TIME_W          = 32;
    localparam int PERIOD_W        = 24;
    localparam int ID_W            = 8;
    localparam int DEF_W           = 57;
    localparam int NUM_DEFS        = 4;
    localparam int CFG_IDX_W       = 2;
    localparam int IDX_W           = 2;
    localparam int MASK_W          = 4;
    localparam int NUM_STREAMS_DEF = 4;
    localparam int REM_BITS        = 2;

    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_SET     = 2'd1,
        OP_READ    = 2'd2,
        OP_RESTART = 2'd3
    } op_e;

    typedef enum logic [2:0] {
        KIND_SENT    = 3'd0,
        KIND_SKIPPED = 3'd1,
        KIND_FAILED  = 3'd2,
        KIND_SET     = 3'd3,
        KIND_READ    = 3'd4,
        KIND_RESTART = 3'd5
    } kind_e;

    typedef struct packed {
        logic              enabled;
        logic [TIME_W-1:0] deadline;
    } entry_t;

    typedef struct packed {
        logic             rd_en;
        logic             wr_en;
        logic [IDX_W-1:0] idx;
        entry_t           wr_entry;
    } mem_req_t;

    typedef struct packed {
        logic                start;
        logic [TIME_W-1:0]   dividend;
        logic [PERIOD_W-1:0] divisor;
    } rem_req_t;

    typedef struct packed {
        logic                busy;
        logic                done;
        logic [PERIOD_W-1:0] rem;
    } rem_stat_t;

    typedef struct packed {
        kind_e            kind;
        logic [IDX_W-1:0] stream_idx;
        logic [ID_W-1:0]  out_id;
        logic             found;
        logic             enabled_flag;
        logic             last;
    } result_t;

    function automatic logic [PERIOD_W-1:0] def_period(input logic [DEF_W-1:0] d);
        return d[23:0];
    endfunction

    function automatic logic [PERIOD_W-1:0] def_phase(input logic [DEF_W-1:0] d);
        return d[47:24];
    endfunction

    function automatic logic [ID_W-1:0] def_id(input logic [DEF_W-1:0] d);
        return d[55:48];
    endfunction

    function automatic logic def_enable(input logic [DEF_W-1:0] d);
        return d[56];
    endfunction

endpackage

>>> src/pss_cmd_if.sv
// command channel of the periodic stream scheduler: valid, ready and one command word
// depends on pss_pkg for field widths
interface pss_cmd_if;
    logic                             valid;
    logic                             ready;
    logic [1:0]                       op;
    logic [pss_pkg::TIME_W-1:0]       now_ms;
    logic [pss_pkg::ID_W-1:0]         stream_id;
    logic                             enable;
    logic [pss_pkg::MASK_W-1:0]       ready_mask;
    logic [pss_pkg::MASK_W-1:0]       fail_mask;

    modport source (output valid, op, now_ms, stream_id, enable, ready_mask, fail_mask,
                    input ready);
    modport sink (input valid, op, now_ms, stream_id, enable, ready_mask, fail_mask,
                  output ready);
endinterface

>>> src/pss_res_if.sv
// result channel of the periodic stream scheduler: valid, ready and one result word
// depends on pss_pkg for field widths
interface pss_res_if;
    logic                        valid;
    logic                        ready;
    logic [2:0]                  kind;
    logic [pss_pkg::IDX_W-1:0]   stream_idx;
    logic [pss_pkg::ID_W-1:0]    out_id;
    logic                        found;
    logic                        enabled_flag;
    logic                        last;

    modport source (output valid, kind, stream_idx, out_id, found, enabled_flag, last,
                    input ready);
    modport sink (input valid, kind, stream_idx, out_id, found, enabled_flag, last,
                  output ready);
endinterface

>>> src/pss_rem.sv
// iterative remainder unit for the deadline catch-up, two quotient bits per cycle
// depends on pss_pkg and periodic_stream_scheduler_top_macros.svh
`include "periodic_stream_scheduler_top_macros.svh"

module pss_rem
(
    input  logic                clk,
    input  logic                rst_n,
    input  pss_pkg::rem_req_t   req,
    output pss_pkg::rem_stat_t  stat
);

    localparam int TW    = pss_pkg::TIME_W;
    localparam int PW    = pss_pkg::PERIOD_W;
    localparam int STEPS = pss_pkg::TIME_W / pss_pkg::REM_BITS;
    localparam int CNT_W = $clog2(STEPS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(STEPS - 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [TW-1:0]    dvd_reg, dvd_next;
    logic [PW-1:0]    rem_reg, rem_next;
    logic [PW-1:0]    dvs_reg, dvs_next;

    always_comb
    begin
        logic [PW:0]   t;
        logic [PW-1:0] r;
        logic [TW-1:0] q;
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        r = rem_reg;
        q = dvd_reg;
        t = '0;
        for (int i = 0; i < pss_pkg::REM_BITS; i++)
        begin
            t = {r, q[TW-1]};
            q = {q[TW-2:0], 1'b0};
            if (t >= {1'b0, dvs_reg})
            begin
                t = t - {1'b0, dvs_reg};
            end
            r = t[PW-1:0];
        end
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            dvd_next = q;
            rem_next = r;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign stat.rem  = rem_reg;

    `PSS_ASSERT(a_rem_below_divisor, done_reg |-> (rem_reg < dvs_reg), "remainder not below divisor")
    `PSS_ASSERT_NEVER(a_rem_busy_done, busy_reg && done_reg, "remainder unit busy and done")

endmodule

>>> src/pss_mem.sv
// per-stream state memory: enable and deadline, registered read
// depends on pss_pkg; entries never written since reset read as zero
module pss_mem
#(
    parameter int NUM_STREAMS = pss_pkg::NUM_STREAMS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  pss_pkg::mem_req_t  req,
    output pss_pkg::entry_t    rd_entry
);

    localparam int AW = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;

    pss_pkg::entry_t         mem_reg [NUM_STREAMS];
    logic [NUM_STREAMS-1:0]  valid_reg;
    pss_pkg::entry_t         rd_data_reg;
    logic                    rd_valid_reg;
    logic [AW-1:0]           addr;

    assign addr = req.idx[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem_reg[addr] <= req.wr_entry;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem_reg[addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                valid_reg[addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_valid_reg <= valid_reg[addr];
            end
        end
    end

    assign rd_entry = rd_valid_reg ? rd_data_reg : '0;

endmodule

>>> src/periodic_stream_scheduler_top.sv
// Periodic stream scheduler. Each command word is taken only while the sequencer is idle;
// the sequencer then visits streams 0 to NUM_STREAMS-1 one at a time through the single
// port of the state memory, reading each stream, then evaluating it and writing it back;
// a stream that is not due is not written back, and a tick stops at a failed stream. For
// each sent or skipped stream with a nonzero period, the remainder unit finds the catch-up
// step (two bits per cycle over a 32-bit gap) before the write-back. Results leave through
// an output register; a tick holds back one result so that the last one can carry the last
// flag, and the walk waits while that register is still full. The user must write stream
// definitions on the cfg port only while the block is idle; the block does not enforce this.
// depends on pss_pkg, pss_cmd_if, pss_res_if, pss_rem, pss_mem and the macros header
`include "periodic_stream_scheduler_top_macros.svh"

module periodic_stream_scheduler_top
#(
    parameter int NUM_STREAMS = pss_pkg::NUM_STREAMS_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [pss_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pss_pkg::DEF_W-1:0]       cfg_data,
    pss_cmd_if.sink                         cmd,
    pss_res_if.source                       res
);

    localparam int TW = pss_pkg::TIME_W;
    localparam int PW = pss_pkg::PERIOD_W;
    localparam int IW = pss_pkg::IDX_W;
    localparam int MW = pss_pkg::MASK_W;
    localparam logic [IW-1:0] K_LAST = IW'(NUM_STREAMS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_EVAL,
        S_DIV,
        S_FIN
    } state_t;

    logic [pss_pkg::DEF_W-1:0] def_reg [pss_pkg::NUM_DEFS];

    state_t                         state_reg, state_next;
    logic [IW-1:0]                  k_reg, k_next;
    pss_pkg::op_e                   op_reg, op_next;
    logic [TW-1:0]                  now_reg, now_next;
    logic [pss_pkg::ID_W-1:0]       sid_reg, sid_next;
    logic                           en_reg, en_next;
    logic [MW-1:0]                  ready_reg, ready_next;
    logic [MW-1:0]                  fail_reg, fail_next;
    logic [TW-1:0]                  last_tick_reg, last_tick_next;
    logic                           found_reg, found_next;
    logic                           flag_reg, flag_next;
    logic                           pend_valid_reg, pend_valid_next;
    pss_pkg::result_t               pend_reg, pend_next;
    logic                           out_valid_reg, out_valid_next;
    pss_pkg::result_t               out_reg, out_next;

    pss_pkg::mem_req_t              mem_req;
    pss_pkg::entry_t                rd_entry;
    pss_pkg::rem_req_t              rem_req;
    pss_pkg::rem_stat_t             rem_stat;

    logic [pss_pkg::DEF_W-1:0]      def_cur;
    logic [PW-1:0]                  period;
    logic [pss_pkg::ID_W-1:0]       cur_id;
    logic [TW-1:0]                  diff;
    logic                           due;
    logic                           out_free;
    logic                           can_emit;
    logic                           adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < pss_pkg::NUM_DEFS; i++)
            begin
                def_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            def_reg[cfg_index] <= cfg_data;
        end
    end

    pss_mem #(
        .NUM_STREAMS (NUM_STREAMS)
    ) u_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (mem_req),
        .rd_entry (rd_entry)
    );

    pss_rem u_rem (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (rem_req),
        .stat  (rem_stat)
    );

    assign def_cur  = def_reg[k_reg];
    assign period   = pss_pkg::def_period(def_cur);
    assign cur_id   = pss_pkg::def_id(def_cur);
    assign diff     = now_reg - rd_entry.deadline;
    assign due      = rd_entry.enabled && !diff[TW-1];
    assign out_free = !out_valid_reg || res.ready;
    assign can_emit = !pend_valid_reg || out_free;

    always_comb
    begin
        state_next      = state_reg;
        k_next          = k_reg;
        op_next         = op_reg;
        now_next        = now_reg;
        sid_next        = sid_reg;
        en_next         = en_reg;
        ready_next      = ready_reg;
        fail_next       = fail_reg;
        last_tick_next  = last_tick_reg;
        found_next      = found_reg;
        flag_next       = flag_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        mem_req         = '0;
        mem_req.idx     = k_reg;
        rem_req         = '0;
        adv             = 1'b0;

        if (out_valid_reg && res.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    op_next         = pss_pkg::op_e'(cmd.op);
                    now_next        = cmd.now_ms;
                    sid_next        = cmd.stream_id;
                    en_next         = cmd.enable;
                    ready_next      = cmd.ready_mask;
                    fail_next       = cmd.fail_mask;
                    k_next          = '0;
                    found_next      = 1'b0;
                    flag_next       = 1'b0;
                    pend_valid_next = 1'b0;
                    if (pss_pkg::op_e'(cmd.op) == pss_pkg::OP_TICK)
                    begin
                        last_tick_next = cmd.now_ms;
                    end
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                mem_req.rd_en = 1'b1;
                state_next    = S_EVAL;
            end
            S_EVAL:
            begin
                case (op_reg)
                    pss_pkg::OP_TICK:
                    begin
                        if (!due)
                        begin
                            adv = 1'b1;
                        end
                        else if (can_emit)
                        begin
                            if (pend_valid_reg)
                            begin
                                out_valid_next = 1'b1;
                                out_next       = pend_reg;
                                out_next.last  = 1'b0;
                            end
                            pend_valid_next        = 1'b1;
                            pend_next.stream_idx   = k_reg;
                            pend_next.out_id       = cur_id;
                            pend_next.found        = 1'b0;
                            pend_next.enabled_flag = 1'b0;
                            pend_next.last         = 1'b0;
                            if (ready_reg[k_reg] && fail_reg[k_reg])
                            begin
                                pend_next.kind = pss_pkg::KIND_FAILED;
                                state_next     = S_FIN;
                            end
                            else
                            begin
                                pend_next.kind = ready_reg[k_reg] ? pss_pkg::KIND_SENT
                                                                  : pss_pkg::KIND_SKIPPED;
                                if (period == '0)
                                begin
                                    mem_req.wr_en             = 1'b1;
                                    mem_req.wr_entry.enabled  = 1'b1;
                                    mem_req.wr_entry.deadline = now_reg;
                                    adv                       = 1'b1;
                                end
                                else
                                begin
                                    rem_req.start    = 1'b1;
                                    rem_req.dividend = diff;
                                    rem_req.divisor  = period;
                                    state_next       = S_DIV;
                                end
                            end
                        end
                    end
                    pss_pkg::OP_SET:
                    begin
                        if (cur_id == sid_reg)
                        begin
                            mem_req.wr_en             = 1'b1;
                            mem_req.wr_entry.enabled  = en_reg;
                            mem_req.wr_entry.deadline = en_reg ? last_tick_reg
                                                               : rd_entry.deadline;
                            found_next                = 1'b1;
                        end
                        adv = 1'b1;
                    end
                    pss_pkg::OP_READ:
                    begin
                        if (cur_id == sid_reg && !found_reg)
                        begin
                            found_next = 1'b1;
                            flag_next  = rd_entry.enabled;
                        end
                        adv = 1'b1;
                    end
                    default:
                    begin
                        mem_req.wr_en             = 1'b1;
                        mem_req.wr_entry.enabled  = pss_pkg::def_enable(def_cur);
                        mem_req.wr_entry.deadline = TW'(pss_pkg::def_phase(def_cur));
                        adv                       = 1'b1;
                    end
                endcase
            end
            S_DIV:
            begin
                if (rem_stat.done)
                begin
                    mem_req.wr_en             = 1'b1;
                    mem_req.wr_entry.enabled  = 1'b1;
                    mem_req.wr_entry.deadline = now_reg - TW'(rem_stat.rem) + TW'(period);
                    adv                       = 1'b1;
                end
            end
            S_FIN:
            begin
                if (op_reg == pss_pkg::OP_TICK)
                begin
                    if (!pend_valid_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (out_free)
                    begin
                        out_valid_next  = 1'b1;
                        out_next        = pend_reg;
                        out_next.last   = 1'b1;
                        pend_valid_next = 1'b0;
                        state_next      = S_IDLE;
                    end
                end
                else if (out_free)
                begin
                    out_valid_next        = 1'b1;
                    out_next.stream_idx   = '0;
                    out_next.found        = found_reg;
                    out_next.enabled_flag = flag_reg;
                    out_next.last         = 1'b1;
                    case (op_reg)
                        pss_pkg::OP_SET:
                        begin
                            out_next.kind   = pss_pkg::KIND_SET;
                            out_next.out_id = sid_reg;
                        end
                        pss_pkg::OP_READ:
                        begin
                            out_next.kind   = pss_pkg::KIND_READ;
                            out_next.out_id = sid_reg;
                        end
                        default:
                        begin
                            out_next.kind   = pss_pkg::KIND_RESTART;
                            out_next.out_id = '0;
                        end
                    endcase
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (adv)
        begin
            if (k_reg == K_LAST)
            begin
                state_next = S_FIN;
            end
            else
            begin
                k_next     = k_reg + 1'b1;
                state_next = S_RD;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            k_reg          <= '0;
            op_reg         <= pss_pkg::OP_TICK;
            now_reg        <= '0;
            sid_reg        <= '0;
            en_reg         <= 1'b0;
            ready_reg      <= '0;
            fail_reg       <= '0;
            last_tick_reg  <= '0;
            found_reg      <= 1'b0;
            flag_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
            pend_reg       <= '0;
            out_valid_reg  <= 1'b0;
            out_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            k_reg          <= k_next;
            op_reg         <= op_next;
            now_reg        <= now_next;
            sid_reg        <= sid_next;
            en_reg         <= en_next;
            ready_reg      <= ready_next;
            fail_reg       <= fail_next;
            last_tick_reg  <= last_tick_next;
            found_reg      <= found_next;
            flag_reg       <= flag_next;
            pend_valid_reg <= pend_valid_next;
            pend_reg       <= pend_next;
            out_valid_reg  <= out_valid_next;
            out_reg        <= out_next;
        end
    end

    assign cmd.ready        = (state_reg == S_IDLE);
    assign res.valid        = out_valid_reg;
    assign res.kind         = out_reg.kind;
    assign res.stream_idx   = out_reg.stream_idx;
    assign res.out_id       = out_reg.out_id;
    assign res.found        = out_reg.found;
    assign res.enabled_flag = out_reg.enabled_flag;
    assign res.last         = out_reg.last;

    `PSS_ASSERT_NEVER(a_mem_no_rw, mem_req.rd_en && mem_req.wr_en, "state memory read and write together")
    `PSS_ASSERT(a_pend_tick_only, pend_valid_reg |-> (op_reg == pss_pkg::OP_TICK), "held result outside a tick")
    `PSS_ASSERT(a_div_has_unit, (state_reg == S_DIV) |-> (rem_stat.busy || rem_stat.done), "catch-up wait with idle remainder unit")
    `PSS_ASSERT(a_idle_no_pend, (state_reg == S_IDLE) |-> !pend_valid_reg, "held result left behind at idle")

endmodule
